FILE: hw/rtl/pcfd_pkg.sv
// shared types and constants for the filtered-derivative pid unit
// no dependencies; used by the multiplier, divider and controller rtl files
`default_nettype none

package pcfd_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_GAIN_P  = 3'd0;
  localparam logic [2:0] REG_GAIN_I  = 3'd1;
  localparam logic [2:0] REG_GAIN_D  = 3'd2;
  localparam logic [2:0] REG_ALPHA   = 3'd3;
  localparam logic [2:0] REG_LIM_LOW = 3'd4;
  localparam logic [2:0] REG_LIM_HI  = 3'd5;

  // time step bounds and scale
  localparam logic [16:0] STEP_MAX  = 17'd100000;
  localparam logic [19:0] US_PER_S  = 20'd1000000;
  localparam logic [55:0] HALF_S_US = 56'd500000;

  // 48 bit saturation bounds
  localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

  // serial multiplier: a is 50 bit signed, b is 33 bit signed
  typedef struct packed {
    logic               start;
    logic               frac;
    logic signed [49:0] a;
    logic signed [32:0] b;
  } pcfd_mul_cmd_t;

  typedef struct packed {
    logic               done;
    logic signed [65:0] res;
  } pcfd_mul_rsp_t;

  // serial divider: unsigned 56 bit numerator over 20 bit denominator
  typedef struct packed {
    logic        start;
    logic [55:0] num;
    logic [19:0] den;
  } pcfd_div_cmd_t;

  typedef struct packed {
    logic        done;
    logic [55:0] quo;
  } pcfd_div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pcfd_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle
// optional floor division by 65536; depends on pcfd_pkg
`default_nettype none

module pcfd_mul (
  input  logic                    clk,
  input  logic                    rst,
  input  pcfd_pkg::pcfd_mul_cmd_t cmd,
  output pcfd_pkg::pcfd_mul_rsp_t rsp
);
  import pcfd_pkg::*;

  logic        busy;
  logic        fin;
  logic [5:0]  cnt;
  logic [49:0] mag_a;
  logic [82:0] prod;
  logic        neg;
  logic        frac;
  logic [50:0] psum;
  logic [65:0] qmag;

  // add the multiplicand when the current multiplier bit is set
  always_comb begin
    psum = {1'b0, prod[82:33]} + (prod[0] ? {1'b0, mag_a} : 51'd0);
    if (frac) begin
      qmag = prod[81:16] + {65'd0, neg && (prod[15:0] != 16'd0)};
    end else begin
      qmag = prod[65:0];
    end
  end

  // shift-add sequence over the 33 multiplier bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      fin      <= 1'b0;
      if (cmd.start) begin
        busy  <= 1'b1;
        cnt   <= 6'd0;
        mag_a <= cmd.a[49] ? 50'(-cmd.a) : 50'(cmd.a);
        prod  <= {50'd0, (cmd.b[32] ? 33'(-cmd.b) : 33'(cmd.b))};
        neg   <= cmd.a[49] ^ cmd.b[32];
        frac  <= cmd.frac;
      end else if (busy) begin
        prod <= {psum, prod[32:1]};
        cnt  <= cnt + 6'd1;
        if (cnt == 6'd32) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) begin
        rsp.done <= 1'b1;
        rsp.res  <= neg ? -$signed(qmag) : $signed(qmag);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pcfd_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on pcfd_pkg
`default_nettype none

module pcfd_div (
  input  logic                    clk,
  input  logic                    rst,
  input  pcfd_pkg::pcfd_div_cmd_t cmd,
  output pcfd_pkg::pcfd_div_rsp_t rsp
);
  import pcfd_pkg::*;

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [19:0] rem;
  logic [19:0] den;
  logic [55:0] quo;
  logic [20:0] trial;
  logic        ge;

  // trial subtract of the next numerator bit
  always_comb begin
    trial = {rem, quo[55]};
    ge    = trial >= {1'b0, den};
  end

  // numerator shifts out on top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rem  <= 20'd0;
        den  <= cmd.den;
        quo  <= cmd.num;
      end else if (busy) begin
        rem <= ge ? 20'(trial - {1'b0, den}) : trial[19:0];
        quo <= {quo[54:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd55) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

`default_nettype wire

FILE: hw/rtl/pid_controller_filtered_derivative_unit.sv
// pid controller with clamped integral term and filtered derivative, Q16.16
// depends on pcfd_pkg, pcfd_mul, pcfd_div
//
//   channel | signals                              | role
//   in      | in_valid in_ready target measured step_us | one sample
//   out     | out_valid out_ready drive            | saturated output
//   cfg     | cfg_we cfg_index cfg_data            | register writes
//
// from acceptance to the output register one sample goes through six passes
// of the shared 33 bit serial multiplier, two passes of the 56 bit serial
// divider and a final sum step.
// a new item is taken once the previous one reaches the output register.
// reset is synchronous and restores gains, limits and all controller state.
// a held result on the output blocks only the final sum step.
`default_nettype none

module pid_controller_filtered_derivative_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] target,
  input  logic [31:0] measured,
  input  logic [19:0] step_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] drive,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import pcfd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PMUL, S_MMUL, S_IDIV, S_IMUL, S_DMUL, S_DDIV, S_FMUL, S_GMUL, S_SUM
  } state_t;

  state_t state;

  // configuration
  logic signed [31:0] gain_p, gain_i, gain_d, limit_low, limit_high;
  logic [16:0]        alpha;

  // controller state
  logic signed [47:0] integ, filt;
  logic signed [32:0] prev;

  // per-item working registers
  logic signed [32:0] err;
  logic [16:0]        stepc;
  logic signed [49:0] p;
  logic signed [65:0] iv, dres;

  pcfd_mul_cmd_t mul_cmd;
  pcfd_mul_rsp_t mul_rsp;
  pcfd_div_cmd_t div_cmd;
  pcfd_div_rsp_t div_rsp;

  logic signed [32:0] err_in;
  logic [16:0]        step_in;
  logic [32:0]        err_mag;
  logic signed [33:0] diff;
  logic [33:0]        diff_mag;
  logic signed [57:0] isum;
  logic signed [47:0] integ_sat;
  logic signed [65:0] lo66, hi66, iv_clamp;
  logic signed [47:0] raw;
  logic signed [65:0] fsum;
  logic signed [47:0] filt_sat;
  logic signed [65:0] tsum, lim_lo66, lim_hi66, tclamp;

  // sample front end
  always_comb begin
    err_in = $signed({target[31], target}) - $signed({measured[31], measured});
    if (step_us == 20'd0) begin
      step_in = 17'd1;
    end else if (step_us > {3'd0, STEP_MAX}) begin
      step_in = STEP_MAX;
    end else begin
      step_in = step_us[16:0];
    end
    err_mag  = err[32] ? 33'(-err) : 33'(err);
    diff     = $signed({err[32], err}) - $signed({prev[32], prev});
    diff_mag = diff[33] ? 34'(-diff) : 34'(diff);
  end

  // integral update, saturating at 48 bits
  always_comb begin
    isum = $signed({{10{integ[47]}}, integ})
         + (err[32] ? -$signed({2'b00, div_rsp.quo}) : $signed({2'b00, div_rsp.quo}));
    if (isum > $signed({{10{S48_MAX[47]}}, S48_MAX})) begin
      integ_sat = S48_MAX;
    end else if (isum < $signed({{10{S48_MIN[47]}}, S48_MIN})) begin
      integ_sat = S48_MIN;
    end else begin
      integ_sat = isum[47:0];
    end
  end

  // integral term clamp so that p plus i stays in the output limits
  always_comb begin
    lo66 = $signed({{34{limit_low[31]}}, limit_low}) - $signed({{16{p[49]}}, p});
    hi66 = $signed({{34{limit_high[31]}}, limit_high}) - $signed({{16{p[49]}}, p});
    iv_clamp = mul_rsp.res;
    if (iv_clamp < lo66) iv_clamp = lo66;
    if (iv_clamp > hi66) iv_clamp = hi66;
  end

  // raw slope from the divider, saturated to 48 bits
  always_comb begin
    if (div_rsp.quo[55:47] != 9'd0) begin
      raw = diff[33] ? S48_MIN : S48_MAX;
    end else begin
      raw = diff[33] ? -$signed({1'b0, div_rsp.quo[46:0]})
                     : $signed({1'b0, div_rsp.quo[46:0]});
    end
  end

  // filter update, saturating at 48 bits
  always_comb begin
    fsum = $signed({{18{filt[47]}}, filt}) + mul_rsp.res;
    if (fsum > $signed({{18{S48_MAX[47]}}, S48_MAX})) begin
      filt_sat = S48_MAX;
    end else if (fsum < $signed({{18{S48_MIN[47]}}, S48_MIN})) begin
      filt_sat = S48_MIN;
    end else begin
      filt_sat = fsum[47:0];
    end
  end

  // output sum and saturation
  always_comb begin
    lim_lo66 = $signed({{34{limit_low[31]}}, limit_low});
    lim_hi66 = $signed({{34{limit_high[31]}}, limit_high});
    tsum     = $signed({{16{p[49]}}, p}) + iv + dres;
    tclamp   = tsum;
    if (tclamp < lim_lo66) tclamp = lim_lo66;
    if (tclamp > lim_hi66) tclamp = lim_hi66;
  end

  assign in_ready = (state == S_IDLE);

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      mul_cmd.start <= 1'b0;
      div_cmd.start <= 1'b0;
      gain_p        <= 32'sd65536;
      gain_i        <= 32'sd0;
      gain_d        <= 32'sd0;
      alpha         <= 17'd65536;
      limit_low     <= 32'sh8000_0000;
      limit_high    <= 32'sh7FFF_FFFF;
      integ         <= 48'sd0;
      filt          <= 48'sd0;
      prev          <= 33'sd0;
    end else begin
      mul_cmd.start <= 1'b0;
      div_cmd.start <= 1'b0;
      // the sum step reloads the output register itself
      if (out_valid && out_ready && state != S_SUM) out_valid <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN_P:  gain_p     <= cfg_data;
          REG_GAIN_I:  gain_i     <= cfg_data;
          REG_GAIN_D:  gain_d     <= cfg_data;
          REG_ALPHA:   alpha      <= cfg_data[16:0];
          REG_LIM_LOW: limit_low  <= cfg_data;
          REG_LIM_HI:  limit_high <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            err           <= err_in;
            stepc         <= step_in;
            mul_cmd.start <= 1'b1;
            mul_cmd.frac  <= 1'b1;
            mul_cmd.a     <= $signed({{17{err_in[32]}}, err_in});
            mul_cmd.b     <= $signed({gain_p[31], gain_p});
            state         <= S_PMUL;
          end
        end
        S_PMUL: begin
          if (mul_rsp.done) begin
            p             <= mul_rsp.res[49:0];
            mul_cmd.start <= 1'b1;
            mul_cmd.frac  <= 1'b0;
            mul_cmd.a     <= $signed({17'd0, err_mag});
            mul_cmd.b     <= $signed({16'd0, stepc});
            state         <= S_MMUL;
          end
        end
        S_MMUL: begin
          if (mul_rsp.done) begin
            div_cmd.start <= 1'b1;
            div_cmd.num   <= mul_rsp.res[55:0] + HALF_S_US;
            div_cmd.den   <= US_PER_S;
            state         <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (div_rsp.done) begin
            integ         <= integ_sat;
            mul_cmd.start <= 1'b1;
            mul_cmd.frac  <= 1'b1;
            mul_cmd.a     <= $signed({{2{integ_sat[47]}}, integ_sat});
            mul_cmd.b     <= $signed({gain_i[31], gain_i});
            state         <= S_IMUL;
          end
        end
        S_IMUL: begin
          if (mul_rsp.done) begin
            iv            <= iv_clamp;
            mul_cmd.start <= 1'b1;
            mul_cmd.frac  <= 1'b0;
            mul_cmd.a     <= $signed({16'd0, diff_mag});
            mul_cmd.b     <= $signed({13'd0, US_PER_S});
            state         <= S_DMUL;
          end
        end
        S_DMUL: begin
          if (mul_rsp.done) begin
            div_cmd.start <= 1'b1;
            div_cmd.num   <= mul_rsp.res[55:0];
            div_cmd.den   <= {3'd0, stepc};
            state         <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (div_rsp.done) begin
            mul_cmd.start <= 1'b1;
            mul_cmd.frac  <= 1'b1;
            mul_cmd.a     <= $signed({{2{raw[47]}}, raw}) - $signed({{2{filt[47]}}, filt});
            mul_cmd.b     <= $signed({16'd0, alpha});
            state         <= S_FMUL;
          end
        end
        S_FMUL: begin
          if (mul_rsp.done) begin
            filt          <= filt_sat;
            mul_cmd.start <= 1'b1;
            mul_cmd.frac  <= 1'b1;
            mul_cmd.a     <= $signed({{2{filt_sat[47]}}, filt_sat});
            mul_cmd.b     <= $signed({gain_d[31], gain_d});
            state         <= S_GMUL;
          end
        end
        S_GMUL: begin
          if (mul_rsp.done) begin
            dres  <= mul_rsp.res;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (!out_valid || out_ready) begin
            drive     <= tclamp[31:0];
            out_valid <= 1'b1;
            prev      <= err;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  pcfd_mul u_mul (
    .clk (clk),
    .rst (rst),
    .cmd (mul_cmd),
    .rsp (mul_rsp)
  );

  pcfd_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .rsp (div_rsp)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/pcfd_checker.sv
// port-level checks for the filtered-derivative pid unit
// bound to pid_controller_filtered_derivative_unit; no other dependencies
`default_nettype none

module pcfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] drive
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive))
    else $error("drive changed while held");

  // an accepted item makes the unit busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready after accept");

  // the first multiply alone keeps the unit busy for many cycles
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##32 !in_ready)
    else $error("item finished too early");

  // a new result comes with the input side opening up
  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result without ready input");

endmodule

bind pid_controller_filtered_derivative_unit pcfd_checker u_pcfd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .drive     (drive)
);

`default_nettype wire

FILE: verif/tb_pid_controller_filtered_derivative_unit.sv
// testbench for the filtered-derivative pid unit: random and directed samples
// depends on pcfd_pkg and pid_controller_filtered_derivative_unit
`default_nettype none

module tb_pid_controller_filtered_derivative_unit;
  import pcfd_pkg::*;

  typedef struct packed {
    logic [31:0] target;
    logic [31:0] measured;
    logic [19:0] step_us;
  } sample_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] target;
  logic [31:0] measured;
  logic [19:0] step_us;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] drive;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  pid_controller_filtered_derivative_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .target(target), .measured(measured), .step_us(step_us),
    .out_valid(out_valid), .out_ready(out_ready), .drive(drive),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int TAIL_CYCLES     = 400;

  // index with no register behind it
  localparam logic [2:0] REG_NONE = 3'd7;

  // controller model state and registers
  longint kp, ki, kd, alpha, lim_lo, lim_hi;
  longint integ, prev_err, filt_d;

  sample_t     pending_samples[$];
  logic [31:0] expected_drive[$];
  int          mismatches;
  int          idle_cycles;
  bit          calm_phase;
  int          in_gap;
  int          out_gap;

  localparam longint S48_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint S48_LO = -S48_HI - 1;

  function automatic longint clip(longint x, longint lo, longint hi);
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    return x;
  endfunction

  // floor(a*b/65536) at full width
  function automatic longint q16_product(longint a, longint b);
    logic signed [127:0] prod;
    prod = $signed(128'(a)) * $signed(128'(b));
    prod = prod >>> 16;
    return longint'(prod);
  endfunction

  // one controller sample; updates model state and returns the drive value
  function automatic logic [31:0] pid_sample(sample_t s);
    longint err, p, iv, d, sum, diff, raw, dt, mag, q;
    err = longint'($signed(s.target)) - longint'($signed(s.measured));
    dt = s.step_us;
    if (dt < 1) dt = 1;
    if (dt > 100000) dt = 100000;
    p = q16_product(err, kp);
    mag = err < 0 ? -err : err;
    q = (mag * dt + 500000) / 1000000;
    integ = clip(integ + (err < 0 ? -q : q), S48_LO, S48_HI);
    iv = q16_product(integ, ki);
    iv = clip(iv, lim_lo - p, lim_hi - p);
    diff = err - prev_err;
    mag = diff < 0 ? -diff : diff;
    q = (mag * 1000000) / dt;
    raw = clip(diff < 0 ? -q : q, S48_LO, S48_HI);
    filt_d = clip(filt_d + q16_product(raw - filt_d, alpha), S48_LO, S48_HI);
    d = q16_product(filt_d, kd);
    sum = clip(p + iv + d, lim_lo, lim_hi);
    prev_err = err;
    return sum[31:0];
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // input driver fed from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_drive.push_back(pid_sample({target, measured, step_us}));
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          {target, measured, step_us} <= pending_samples.pop_front();
          in_valid <= 1'b1;
          if (!calm_phase && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_drive.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected item drive=%h", drive);
        end else begin
          logic [31:0] exp_val;
          exp_val = expected_drive.pop_front();
          if (exp_val !== drive) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("drive mismatch: expected %h actual %h", exp_val, drive);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm_phase && $urandom_range(0, 5) == 0) out_gap <= $urandom_range(1, 12);
      end
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAIN_P:  kp = longint'($signed(val));
      REG_GAIN_I:  ki = longint'($signed(val));
      REG_GAIN_D:  kd = longint'($signed(val));
      REG_ALPHA:   alpha = longint'(val[16:0]);
      REG_LIM_LOW: lim_lo = longint'($signed(val));
      REG_LIM_HI:  lim_hi = longint'($signed(val));
      default: ;
    endcase
  endtask

  // wait until every queued sample has gone through and the unit is idle
  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_drive.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sd524288);
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int mode;
    mode = $urandom_range(0, 9) < 6 ? 1 + $urandom_range(0, 1) : $urandom_range(0, 3);
    s.target = rand_value(mode);
    s.measured = rand_value(mode);
    case ($urandom_range(0, 5))
      0: s.step_us = 20'($urandom());
      1: s.step_us = 20'($urandom_range(0, 2));
      2: s.step_us = 20'($urandom_range(99990, 100010));
      default: s.step_us = 20'($urandom_range(1, 20000));
    endcase
    return s;
  endfunction

  // register settings applied between phases
  task automatic random_config(int k);
    logic [31:0] lo, hi;
    write_reg(REG_GAIN_P, k == 1 ? 32'h7FFF_FFFF : k == 2 ? 32'h8000_0000 : rand_value(2));
    write_reg(REG_GAIN_I, k == 1 ? 32'h8000_0000 : k == 2 ? 32'h7FFF_FFFF : rand_value(2));
    write_reg(REG_GAIN_D, k == 3 ? 32'h8000_0000 : $urandom_range(0, 3) == 0 ?
              $urandom() : rand_value(2) >>> 8);
    write_reg(REG_ALPHA, k == 1 ? 32'h1FFFF : k == 2 ? 32'd0 : k == 3 ? 32'd65536 :
              $urandom());
    lo = rand_value(2);
    hi = rand_value(2);
    // crossed limits now and then
    if (k != 4 && $signed(lo) > $signed(hi)) {lo, hi} = {hi, lo};
    write_reg(REG_LIM_LOW, k == 1 ? 32'h8000_0000 : k == 2 ? 32'h7FFF_FFFF : lo);
    write_reg(REG_LIM_HI, k == 1 ? 32'h7FFF_FFFF : k == 2 ? 32'h8000_0000 : hi);
    write_reg(REG_NONE, $urandom());
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_GAIN_P;
    cfg_data = '0;
    in_valid = 1'b0;
    target = '0;
    measured = '0;
    step_us = '0;
    out_ready = 1'b0;
    mismatches = 0;
    calm_phase = 1'b0;
    kp = 65536; ki = 0; kd = 0; alpha = 65536;
    lim_lo = -64'sd2147483648; lim_hi = 64'sd2147483647;
    integ = 0; prev_err = 0; filt_d = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, step clamping, windup under reset gains
    pending_samples.push_back({32'h7FFF_FFFF, 32'h8000_0000, 20'd0});
    pending_samples.push_back({32'h8000_0000, 32'h7FFF_FFFF, 20'hFFFFF});
    pending_samples.push_back({32'h0001_0000, 32'h0000_0000, 20'd100000});
    pending_samples.push_back({32'h0001_0000, 32'h0000_0000, 20'd100001});
    pending_samples.push_back({32'h0000_0000, 32'h0000_0000, 20'd1});
    drain();
    write_reg(REG_GAIN_P, 32'h0002_0000);
    write_reg(REG_GAIN_I, 32'h0001_0000);
    write_reg(REG_GAIN_D, 32'h0000_8000);
    write_reg(REG_ALPHA, 32'd70000);
    write_reg(REG_LIM_LOW, 32'h0010_0000);
    write_reg(REG_LIM_HI, 32'hFFF0_0000);
    for (int i = 0; i < 8; i++)
      pending_samples.push_back({i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                                 32'h0000_0000, i[1] ? 20'd1 : 20'hFFFFF});
    drain();
    for (int k = 1; k <= 4; k++) begin
      random_config(k);
      for (int i = 0; i < 3; i++) pending_samples.push_back(random_sample());
      drain();
    end

    // random phases with changing settings
    for (int ph = 0; ph < 25; ph++) begin
      random_config(ph % 6 == 0 ? 1 + $urandom_range(0, 3) : 0);
      if (ph >= 22) calm_phase = 1'b1;
      for (int i = 0; i < 50; i++) pending_samples.push_back(random_sample());
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_drive.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
